// File: sv/dagc_pkg.sv
package dagc_pkg;

  // default graph size
  localparam int MaxNodesDefault = 64;

  // field widths
  localparam int NodeWidth  = 6;
  localparam int CountWidth = 7;
  localparam int AddrWidth  = 3;
  localparam int DataWidth  = 32;

  // reset node count
  localparam logic [CountWidth-1:0] NodeCountReset = CountWidth'(64);

  // register index of node_count
  localparam logic RegNodeCount = 1'b0;

  // result codes
  typedef enum logic [1:0] {
    OUT_ADDED     = 2'd0,
    OUT_CYCLE     = 2'd1,
    OUT_SELF_LOOP = 2'd2,
    OUT_RANGE     = 2'd3
  } outcome_t;

endpackage

// File: sv/dag_edge_insert_cycle_check.sv
// Keeps a directed acyclic graph of up to MAX_NODES nodes as an adjacency memory that is empty
// after reset, and checks each proposed edge tail_node -> head_node before adding it. A command
// transfer happens when start is high while busy is low; exactly one result follows, shown on
// outcome for a single cycle with done high, and the receiver cannot stall it. Range failures
// and self-loops answer in the cycle after the transfer. Other edges run a reachability search
// from head_node that, within each pass, reads one adjacency row per cycle through the single
// memory read port, sweeping nodes 0..n-1 in passes until a pass expands nothing, with n the
// effective node count; the search takes one pass for an empty neighborhood and at most n+1
// passes, and an added edge also goes through the WRITE state before its result shows. A new
// command can be taken in the cycle its result shows. node_count sits at byte address 0 of
// the APB port and may be changed only while busy is low and no result is pending.
module dag_edge_insert_cycle_check #(
  parameter int MAX_NODES = dagc_pkg::MaxNodesDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic [dagc_pkg::NodeWidth-1:0]   tail_node,
  input  logic [dagc_pkg::NodeWidth-1:0]   head_node,
  // result side
  output logic                             done,
  output logic [1:0]                       outcome,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dagc_pkg::AddrWidth-1:0]   paddr,
  input  logic [dagc_pkg::DataWidth-1:0]   pwdata,
  output logic [dagc_pkg::DataWidth-1:0]   prdata,
  output logic                             pready
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [2:0] {
    IDLE,
    SEED,
    SCAN,
    DRAIN,
    WRITE
  } state_t;

  state_t                          state;
  logic [dagc_pkg::CountWidth-1:0] node_count;
  logic [CW-1:0]                   n_eff;
  logic [CW-1:0]                   n_reg;
  logic [MAX_NODES-1:0]            col_mask_next;
  logic [MAX_NODES-1:0]            col_mask;
  logic [MAX_NODES-1:0]            reached;
  logic [MAX_NODES-1:0]            expanded;
  logic [MAX_NODES-1:0]            row_valid;
  logic [IW-1:0]                   tail_reg;
  logic [IW-1:0]                   head_reg;
  logic [IW-1:0]                   k;
  logic                            any_exp;
  logic                            pend;
  logic                            accept;
  logic                            in_range;
  logic                            expand;
  logic                            last_k;

  // adjacency memory and its read port
  logic [MAX_NODES-1:0]            adj_mem [MAX_NODES];
  logic [IW-1:0]                   rd_addr;
  logic [MAX_NODES-1:0]            rd_data;
  logic                            rd_hit;
  logic [MAX_NODES-1:0]            rd_row;
  logic                            wr_en;
  logic [MAX_NODES-1:0]            wr_row;

  // configuration register write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dagc_pkg::NodeCountReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == dagc_pkg::RegNodeCount) begin
      node_count <= pwdata[dagc_pkg::CountWidth-1:0];
    end
  end

  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == dagc_pkg::RegNodeCount) begin
      prdata = dagc_pkg::DataWidth'(node_count);
    end
  end

  // effective node count and the column mask it implies
  always_comb begin
    if (32'(node_count) > 32'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count);
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      col_mask_next[i] = (32'(i) < 32'(n_eff));
    end
  end

  assign busy     = (state != IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(tail_node) < 32'(n_eff)) && (32'(head_node) < 32'(n_eff));
  assign expand   = (state == SCAN) && reached[k] && !expanded[k];
  assign last_k   = (k == IW'(n_reg - CW'(1)));
  assign rd_row   = rd_hit ? rd_data : '0;

  // read address follows the sequencer step
  always_comb begin
    case (state)
      IDLE:    rd_addr = IW'(head_node);
      SCAN:    rd_addr = k;
      DRAIN:   rd_addr = tail_reg;
      default: rd_addr = tail_reg;
    endcase
  end

  assign wr_en  = (state == WRITE);
  assign wr_row = rd_row | (MAX_NODES'(1) << head_reg);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem[tail_reg] <= wr_row;
    end
    rd_data <= adj_mem[rd_addr];
    rd_hit  <= row_valid[rd_addr];
  end

  // sequencer: seed from head row, sweep rows until closure, then decide
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      done      <= 1'b0;
      outcome   <= dagc_pkg::OUT_ADDED;
      row_valid <= '0;
      any_exp   <= 1'b0;
      pend      <= 1'b0;
      k         <= '0;
    end else begin
      case (state)
        IDLE: begin
          // range failures and self-loops answer right away
          done <= accept && !(in_range && tail_node != head_node);
          if (accept) begin
            tail_reg <= IW'(tail_node);
            head_reg <= IW'(head_node);
            n_reg    <= n_eff;
            col_mask <= col_mask_next;
            if (!in_range) begin
              outcome <= dagc_pkg::OUT_RANGE;
            end else if (tail_node == head_node) begin
              outcome <= dagc_pkg::OUT_SELF_LOOP;
            end else begin
              state <= SEED;
            end
          end
        end
        SEED: begin
          done     <= 1'b0;
          reached  <= rd_row & col_mask;
          expanded <= '0;
          k        <= '0;
          any_exp  <= 1'b0;
          pend     <= 1'b0;
          state    <= SCAN;
        end
        SCAN: begin
          done <= 1'b0;
          if (pend) begin
            reached <= reached | (rd_row & col_mask);
          end
          pend <= expand;
          if (expand) begin
            expanded[k] <= 1'b1;
            any_exp     <= 1'b1;
          end
          if (last_k) begin
            k     <= '0;
            state <= DRAIN;
          end else begin
            k <= k + IW'(1);
          end
        end
        DRAIN: begin
          done <= !any_exp && reached[tail_reg];
          pend <= 1'b0;
          if (pend) begin
            reached <= reached | (rd_row & col_mask);
          end
          if (any_exp) begin
            // something was expanded, sweep again
            any_exp <= 1'b0;
            state   <= SCAN;
          end else if (reached[tail_reg]) begin
            outcome <= dagc_pkg::OUT_CYCLE;
            state   <= IDLE;
          end else begin
            state <= WRITE;
          end
        end
        WRITE: begin
          row_valid[tail_reg] <= 1'b1;
          done                <= 1'b1;
          outcome             <= dagc_pkg::OUT_ADDED;
          state               <= IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end

  // a result only shows once the sequencer is back in idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // out-of-range commands answer right away with the range code
  assert property (@(posedge clk) disable iff (rst)
    (accept && !in_range) |=> (done && outcome == dagc_pkg::OUT_RANGE))
    else $error("range reject not reported");

  // the sweep index never leaves the active node range
  assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (32'(k) < 32'(n_reg)))
    else $error("sweep index out of range");

  // a row write only happens after a search that missed the tail
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ($past(state) == DRAIN && !$past(reached[tail_reg])))
    else $error("edge written without a clean search");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int MaxNodes  = dagc_pkg::MaxNodesDefault;
  localparam int NumProbes = 23;
  localparam int NumPhases = 10;

  // node counts and transfer counts of the random phases, small graphs mostly
  localparam int PhaseCounts [NumPhases] = '{8, 16, 64, 4, 32, 2, 127, 12, 1, 24};
  localparam int PhaseItems  [NumPhases] = '{80, 80, 50, 50, 60, 30, 50, 70, 20, 60};

  typedef struct {
    bit                              set_count;
    logic [dagc_pkg::CountWidth-1:0] count;
    logic [dagc_pkg::NodeWidth-1:0]  tail;
    logic [dagc_pkg::NodeWidth-1:0]  head;
    bit                              pinned;
    dagc_pkg::outcome_t              want;
  } edge_probe_t;

  typedef struct {
    bit                 pinned;
    dagc_pkg::outcome_t want;
  } probe_tag_t;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic [dagc_pkg::NodeWidth-1:0]  tail_node;
  logic [dagc_pkg::NodeWidth-1:0]  head_node;
  logic                            done;
  logic [1:0]                      outcome;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [dagc_pkg::AddrWidth-1:0]  paddr;
  logic [dagc_pkg::DataWidth-1:0]  pwdata;
  logic [dagc_pkg::DataWidth-1:0]  prdata;
  logic                            pready;

  // mirror of the graph and the node count register
  logic [MaxNodes-1:0]             graph_rows [MaxNodes];
  logic [dagc_pkg::CountWidth-1:0] node_count_mirror;

  dagc_pkg::outcome_t              pending_outcomes [$];
  probe_tag_t                      probe_tags [$];
  edge_probe_t                     probe_table [NumProbes];
  int                              mismatch_count;

  dag_edge_insert_cycle_check #(
    .MAX_NODES(MaxNodes)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .tail_node(tail_node),
    .head_node(head_node),
    .done     (done),
    .outcome  (outcome),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #400_000_000;
    $display("Verification failed");
    $finish;
  end

  // effective node count, clamped to the graph size
  function automatic int active_nodes();
    return (node_count_mirror > MaxNodes) ? MaxNodes : int'(node_count_mirror);
  endfunction

  // outcome of one proposed edge; adds the edge to the mirror when accepted
  function automatic dagc_pkg::outcome_t predict_edge_outcome(
      input logic [dagc_pkg::NodeWidth-1:0] tail,
      input logic [dagc_pkg::NodeWidth-1:0] head);
    int                  n;
    logic [MaxNodes-1:0] live;
    logic [MaxNodes-1:0] reach;
    logic [MaxNodes-1:0] expanded;
    logic [MaxNodes-1:0] step;
    bit                  grew;
    n = active_nodes();
    live = (n >= MaxNodes) ? '1 : ((MaxNodes'(1) << n) - MaxNodes'(1));
    if (int'(tail) >= n || int'(head) >= n) return dagc_pkg::OUT_RANGE;
    if (tail == head) return dagc_pkg::OUT_SELF_LOOP;
    // closure of the nodes reachable from head, ignoring nodes out of range
    reach = graph_rows[head] & live;
    expanded = '0;
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (reach[k] && !expanded[k]) begin
          expanded[k] = 1'b1;
          step = graph_rows[k] & live;
          if ((step & ~reach) != '0) begin
            reach = reach | step;
            grew = 1'b1;
          end
        end
      end
    end
    if (reach[tail]) return dagc_pkg::OUT_CYCLE;
    graph_rows[tail][head] = 1'b1;
    return dagc_pkg::OUT_ADDED;
  endfunction

  task automatic note_mismatch(input string what, input logic [1:0] want,
                               input logic [1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch: %s, expected outcome %0d, got %0d", $realtime, what, want, got);
  endtask

  // result check and prediction at each command transfer
  always @(posedge clk) begin : result_check
    dagc_pkg::outcome_t want;
    dagc_pkg::outcome_t got;
    probe_tag_t         tag;
    if (!rst) begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          note_mismatch("result with nothing pending", 2'bxx, outcome);
        end else begin
          want = pending_outcomes.pop_front();
          if (outcome !== want) note_mismatch("outcome", want, outcome);
        end
      end
      if (start && !busy) begin
        tag = probe_tags.pop_front();
        got = predict_edge_outcome(tail_node, head_node);
        pending_outcomes.insert(pending_outcomes.size(), tag.pinned ? tag.want : got);
      end
    end
  end

  // one command transfer; start stays high so a burst can follow
  task automatic send_edge(input logic [dagc_pkg::NodeWidth-1:0] tail,
                           input logic [dagc_pkg::NodeWidth-1:0] head,
                           input bit pinned, input dagc_pkg::outcome_t want);
    probe_tags.insert(probe_tags.size(), probe_tag_t'{pinned, want});
    start     <= 1'b1;
    tail_node <= tail;
    head_node <= head;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and wait until every result is back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0 || busy);
  endtask

  // apb register write, setup then access phase
  task automatic write_reg(input logic index, input logic [dagc_pkg::DataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dagc_pkg::AddrWidth'(4 * index);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == dagc_pkg::RegNodeCount) node_count_mirror = value[dagc_pkg::CountWidth-1:0];
  endtask

  // stimulus
  initial begin : stimulus
    int                             n;
    int                             pick;
    int                             burst_left;
    logic [dagc_pkg::NodeWidth-1:0] tail;
    logic [dagc_pkg::NodeWidth-1:0] head;

    // directed probes: corners, error codes, pruned edges after lowering the count
    probe_table = '{
      '{1'b0, 7'd0,   6'd0,  6'd0,  1'b1, dagc_pkg::OUT_SELF_LOOP},
      '{1'b0, 7'd0,   6'd63, 6'd63, 1'b1, dagc_pkg::OUT_SELF_LOOP},
      '{1'b0, 7'd0,   6'd0,  6'd63, 1'b1, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd63, 6'd0,  1'b1, dagc_pkg::OUT_CYCLE},
      '{1'b0, 7'd0,   6'd1,  6'd2,  1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd2,  6'd3,  1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd3,  6'd1,  1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd1,  6'd2,  1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd4,  6'd40, 1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd40, 6'd5,  1'b0, dagc_pkg::OUT_ADDED},
      '{1'b1, 7'd8,   6'd5,  6'd4,  1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd8,  6'd2,  1'b1, dagc_pkg::OUT_RANGE},
      '{1'b0, 7'd0,   6'd2,  6'd8,  1'b1, dagc_pkg::OUT_RANGE},
      '{1'b0, 7'd0,   6'd63, 6'd63, 1'b1, dagc_pkg::OUT_RANGE},
      '{1'b1, 7'd0,   6'd0,  6'd0,  1'b1, dagc_pkg::OUT_RANGE},
      '{1'b0, 7'd0,   6'd0,  6'd1,  1'b1, dagc_pkg::OUT_RANGE},
      '{1'b1, 7'd1,   6'd0,  6'd0,  1'b1, dagc_pkg::OUT_SELF_LOOP},
      '{1'b0, 7'd0,   6'd0,  6'd1,  1'b1, dagc_pkg::OUT_RANGE},
      '{1'b1, 7'd127, 6'd62, 6'd63, 1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd63, 6'd62, 1'b0, dagc_pkg::OUT_ADDED},
      '{1'b1, 7'd64,  6'd40, 6'd4,  1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd42, 6'd21, 1'b0, dagc_pkg::OUT_ADDED},
      '{1'b0, 7'd0,   6'd21, 6'd42, 1'b0, dagc_pkg::OUT_ADDED}
    };

    rst       <= 1'b1;
    start     <= 1'b0;
    tail_node <= '0;
    head_node <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    mismatch_count = 0;
    node_count_mirror = dagc_pkg::NodeCountReset;
    for (int i = 0; i < MaxNodes; i++) graph_rows[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < NumProbes; i++) begin
      if (probe_table[i].set_count) begin
        wait_drained();
        write_reg(dagc_pkg::RegNodeCount, dagc_pkg::DataWidth'(probe_table[i].count));
      end
      send_edge(probe_table[i].tail, probe_table[i].head,
                probe_table[i].pinned, probe_table[i].want);
      if ((i % 3) == 2) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    // random phases, one node count each
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_reg(dagc_pkg::RegNodeCount, dagc_pkg::DataWidth'(PhaseCounts[p]));
      n = active_nodes();
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < PhaseItems[p]; i++) begin
        pick = $urandom_range(0, 15);
        if (n == 0 || pick == 0) begin
          // raw node numbers over the whole node field, out of range for small node counts
          tail = dagc_pkg::NodeWidth'($urandom_range(0, 63));
          head = dagc_pkg::NodeWidth'($urandom_range(0, 63));
        end else if (pick == 1) begin
          tail = dagc_pkg::NodeWidth'($urandom_range(0, n - 1));
          head = tail;
        end else begin
          tail = dagc_pkg::NodeWidth'($urandom_range(0, n - 1));
          head = dagc_pkg::NodeWidth'($urandom_range(0, n - 1));
          if (n > 1 && head == tail) head = dagc_pkg::NodeWidth'((int'(tail) + 1) % n);
        end
        send_edge(tail, head, 1'b0, dagc_pkg::OUT_ADDED);
        burst_left--;
        // end of burst: idle gap, sometimes a full drain
        if (burst_left == 0) begin
          if ($urandom_range(0, 15) == 0) begin
            wait_drained();
          end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
          end
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    // final drain and quiet period
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
sv/dagc_pkg.sv
sv/dag_edge_insert_cycle_check.sv
tb/tb_top.sv
